### hw/rtl/led_matrix_frame_serializer_assert.svh
// Assertion macros shared by the frame serializer RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef LED_MATRIX_FRAME_SERIALIZER_ASSERT_SVH
`define LED_MATRIX_FRAME_SERIALIZER_ASSERT_SVH

// Invariant that must hold at every sampled edge.
`define LMFS_CHECK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define LMFS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/lmfs_pkg.sv
// Package for the LED matrix frame serializer: types, opcodes, phases,
// setup command words and frame address tables. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmfs_pkg;

  localparam int FRAME_BYTES = 128;
  localparam int ADDR_W      = 7;

  typedef logic [1:0]        opcode_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        byte_t;
  typedef logic [3:0]        level_t;
  typedef logic [11:0]       cmd_word_t;

  localparam opcode_t OP_LOAD  = 2'd0;
  localparam opcode_t OP_START = 2'd1;
  localparam opcode_t OP_TICK  = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SEL_ALL,
    PH_CMD,
    PH_SEL_NONE,
    PH_FRAME,
    PH_DATA,
    PH_FINISH
  } phase_t;

  localparam logic [8:0] CMD_SLOTS   = 9'd24;   // 12 bits, two slots each
  localparam logic [8:0] HEADER_BITS = 9'd10;
  localparam logic [8:0] DATA_BITS   = 9'd266;  // header plus 256 pixels
  localparam logic [2:0] SETUP_CMDS  = 3'd7;

  localparam cmd_word_t CMD_SYS_DIS = 12'h800;
  localparam cmd_word_t CMD_COM_OPT = 12'h840;
  localparam cmd_word_t CMD_RC_MSTR = 12'h830;
  localparam cmd_word_t CMD_SYS_EN  = 12'h802;
  localparam cmd_word_t CMD_PWM     = 12'h940;
  localparam cmd_word_t CMD_BLK_OFF = 12'h810;
  localparam cmd_word_t CMD_LED_ON  = 12'h806;

  typedef struct packed {
    logic  en;
    addr_t addr;
    byte_t data;
  } store_wr_t;

  function automatic cmd_word_t setup_word(input logic [2:0] idx, input level_t lvl);
    cmd_word_t w;
    case (idx)
      3'd0:    w = CMD_SYS_DIS;
      3'd1:    w = CMD_COM_OPT;
      3'd2:    w = CMD_RC_MSTR;
      3'd3:    w = CMD_SYS_EN;
      3'd4:    w = CMD_PWM | {7'd0, lvl, 1'b0};
      3'd5:    w = CMD_BLK_OFF;
      default: w = CMD_LED_ON;
    endcase
    return w;
  endfunction

  function automatic addr_t chip_base(input logic [1:0] chip);
    addr_t a;
    case (chip)
      2'd0:    a = 7'd0;
      2'd1:    a = 7'd2;
      2'd2:    a = 7'd32;
      default: a = 7'd34;
    endcase
    return a;
  endfunction

  // Red matrix 1, red matrix 2, green matrix 1, green matrix 2.
  function automatic addr_t matrix_offset(input logic [1:0] m);
    addr_t a;
    case (m)
      2'd0:    a = 7'd64;
      2'd1:    a = 7'd65;
      2'd2:    a = 7'd0;
      default: a = 7'd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/lmfs_channels.sv
// Handshake channel interfaces for the frame serializer.
// Depends on lmfs_pkg for payload types.
`timescale 1ns / 1ps
`default_nettype none

interface lmfs_cmd_if;
  logic              valid;
  logic              ready;
  lmfs_pkg::opcode_t opcode;
  lmfs_pkg::addr_t   byte_index;
  lmfs_pkg::byte_t   byte_value;

  modport source (output valid, opcode, byte_index, byte_value, input ready);
  modport sink   (input valid, opcode, byte_index, byte_value, output ready);
endinterface

interface lmfs_pin_if;
  logic valid;
  logic ready;
  logic select_line;
  logic select_clock;
  logic write_strobe;
  logic serial_data;
  logic busy_res;

  modport source (output valid, select_line, select_clock, write_strobe, serial_data,
                  busy_res, input ready);
  modport sink   (input valid, select_line, select_clock, write_strobe, serial_data,
                  busy_res, output ready);
endinterface

`default_nettype wire

### hw/rtl/led_matrix_frame_serializer.sv
// LED matrix frame serializer, top level.
// Usage:
//   cmd  (sink)   : one item per operation: load frame byte, start refresh, or
//                   one delay tick. Load items write byte_value at byte_index.
//   pins (source) : one item per accepted cmd item, carrying the four pin
//                   levels after the operation plus busy_res (refresh running).
//   cfg_wr_en/cfg_wr_data : write the 4-bit intensity register (reset 15) used
//                   in the PWM duty setup command. Write only while idle.
// Hand-off: an accepted item waits as pending for the frame store read issued at
//   acceptance and for a free result slot, then steps; its result is valid the
//   cycle after the step. No new item is taken until the pending one has stepped,
//   as its frame-store read comes ahead of the sequencer step. cmd.ready is high
//   whenever no item is waiting for its step, so a new item enters while a result still waits.
// Stalls: while pins.ready is low the result holds and the pending item waits.
// Reset: rst (synchronous) returns the sequencer to idle, all pins low,
//   intensity to 15. The frame store is not cleared; a refresh must follow
//   loads of every byte.
// Sequence: seven 12-bit setup commands (MSB first) framed by the chip-select
//   shift patterns, then per controller a select pulse, header 1010000000 and
//   256 pixel bits; a final select pulse ends the refresh.
`timescale 1ns / 1ps
`default_nettype none
`include "led_matrix_frame_serializer_assert.svh"

module led_matrix_frame_serializer #(
  parameter int CHIP_COUNT = 4
) (
  input  wire             clk,
  input  wire             rst,
  lmfs_cmd_if.sink        cmd,
  lmfs_pin_if.source      pins,
  input  wire             cfg_wr_en,
  input  lmfs_pkg::level_t cfg_wr_data
);
  import lmfs_pkg::*;

  localparam int SEL_ALL_SLOTS  = 2 * (CHIP_COUNT + 1);
  localparam int SEL_NONE_SLOTS = 2 * CHIP_COUNT;

  // Intensity register.
  level_t intensity;
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity <= 4'd15;
    end else if (cfg_wr_en) begin
      intensity <= cfg_wr_data;
    end
  end

  // Sequencer state.
  phase_t     phase, phase_next;
  logic [2:0] cmd_idx, cmd_idx_next;
  logic [8:0] bit_cnt, bit_cnt_next;
  logic [2:0] chip_cnt, chip_cnt_next;
  logic [3:0] slot_cnt, slot_cnt_next;
  cmd_word_t  cmd_word;
  logic [3:0] cmd_pos;
  logic       cs, cs_next, sclk, sclk_next, wr, wr_next, sdata, sdata_next;

  // Item hand-off: one item waits here for the store read, then steps.
  logic    pending;
  opcode_t op_q;
  logic    out_valid;
  logic    out_free, accept, step, start, tick;
  byte_t   pix_byte;

  assign out_free   = !out_valid || pins.ready;
  assign cmd.ready  = !pending;
  assign accept     = cmd.valid && !pending;
  assign step       = pending && out_free;
  assign start      = step && (op_q == OP_START);
  assign tick       = step && (op_q == OP_TICK) && (phase != PH_IDLE);

  // Frame store; read the byte for the current pixel slot on every accept.
  store_wr_t  st_wr;
  logic [8:0] pix_n;
  addr_t      rd_addr;

  assign st_wr.en   = accept && (cmd.opcode == OP_LOAD);
  assign st_wr.addr = cmd.byte_index;
  assign st_wr.data = cmd.byte_value;
  assign pix_n      = bit_cnt - HEADER_BITS;
  assign rd_addr    = chip_base(chip_cnt[1:0]) + {2'b00, pix_n[2:0], 2'b00}
                      + matrix_offset(pix_n[7:6]);

  lmfs_frame_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (pix_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        pending <= 1'b1;
      end else if (step) begin
        pending <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (pins.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= cmd.opcode;
    end
  end

  // Shared end-of-phase flags.
  logic [3:0] slot_inc;
  logic [8:0] bit_inc;
  logic [2:0] cmd_inc;
  logic       sel_all_done, cmd_done, sel_none_done, cmds_done, data_done, pix_bit;
  logic       counters_clear;

  assign slot_inc      = slot_cnt + 4'd1;
  assign bit_inc       = bit_cnt + 9'd1;
  assign cmd_inc       = cmd_idx + 3'd1;
  assign sel_all_done  = (slot_inc == 4'(SEL_ALL_SLOTS));
  assign sel_none_done = (slot_inc == 4'(SEL_NONE_SLOTS));
  assign cmd_done      = (bit_inc == CMD_SLOTS);
  assign cmds_done     = (cmd_inc == SETUP_CMDS);
  assign data_done     = (bit_inc == DATA_BITS);
  assign pix_bit       = (bit_cnt < HEADER_BITS) ? ((bit_cnt == 9'd0) || (bit_cnt == 9'd2))
                                                 : pix_byte[~pix_n[5:3]];
  assign counters_clear = (slot_cnt == 4'd0) && (bit_cnt == 9'd0) &&
                          (chip_cnt == 3'd0) && (cmd_idx == 3'd0);

  // Setup word bit picked per slot, so the PWM word sees the level held right now.
  assign cmd_word = setup_word(cmd_idx, intensity);
  assign cmd_pos  = 4'd11 - bit_cnt[4:1];

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (start) begin
      phase_next = PH_SEL_ALL;
    end else if (tick) begin
      case (phase)
        PH_SEL_ALL:  if (sel_all_done) phase_next = PH_CMD;
        PH_CMD:      if (cmd_done) phase_next = PH_SEL_NONE;
        PH_SEL_NONE: begin
          if (sel_none_done) begin
            phase_next = cmds_done ? PH_FRAME : PH_SEL_ALL;
          end
        end
        PH_FRAME: begin
          if (slot_cnt != 4'd0) begin
            phase_next = (chip_cnt >= 3'(CHIP_COUNT)) ? PH_FINISH : PH_DATA;
          end
        end
        PH_DATA:     if (slot_cnt != 4'd0 && data_done) phase_next = PH_FRAME;
        PH_FINISH:   phase_next = PH_IDLE;
        default:     phase_next = PH_IDLE;
      endcase
    end
  end

  // Counters and pin levels.
  always_comb begin
    cmd_idx_next   = cmd_idx;
    bit_cnt_next   = bit_cnt;
    chip_cnt_next  = chip_cnt;
    slot_cnt_next  = slot_cnt;
    cs_next        = cs;
    sclk_next      = sclk;
    wr_next        = wr;
    sdata_next     = sdata;
    if (start) begin
      cmd_idx_next  = 3'd0;
      bit_cnt_next  = 9'd0;
      chip_cnt_next = 3'd0;
      slot_cnt_next = 4'd0;
    end else if (tick) begin
      case (phase)
        PH_SEL_ALL: begin
          cs_next       = 1'b0;
          sclk_next     = slot_cnt[0];
          slot_cnt_next = slot_inc;
          if (sel_all_done) begin
            slot_cnt_next  = 4'd0;
            bit_cnt_next   = 9'd0;
          end
        end
        PH_CMD: begin
          if (!bit_cnt[0]) begin
            wr_next    = 1'b0;
            sdata_next = cmd_word[cmd_pos];
          end else begin
            wr_next = 1'b1;
          end
          bit_cnt_next = bit_inc;
          if (cmd_done) begin
            bit_cnt_next  = 9'd0;
            slot_cnt_next = 4'd0;
          end
        end
        PH_SEL_NONE: begin
          cs_next       = 1'b1;
          sclk_next     = slot_cnt[0];
          slot_cnt_next = slot_inc;
          if (sel_none_done) begin
            slot_cnt_next = 4'd0;
            cmd_idx_next  = cmd_inc;
            if (cmds_done) begin
              cmd_idx_next  = 3'd0;
              chip_cnt_next = 3'd0;
            end
          end
        end
        PH_FRAME: begin
          if (slot_cnt == 4'd0) begin
            sclk_next     = 1'b0;
            cs_next       = (chip_cnt != 3'd0);
            slot_cnt_next = 4'd1;
          end else begin
            sclk_next     = 1'b1;
            slot_cnt_next = 4'd0;
            bit_cnt_next  = 9'd0;
          end
        end
        PH_DATA: begin
          if (slot_cnt == 4'd0) begin
            sclk_next     = 1'b0;
            wr_next       = 1'b0;
            sdata_next    = pix_bit;
            slot_cnt_next = 4'd1;
          end else begin
            wr_next       = 1'b1;
            slot_cnt_next = 4'd0;
            bit_cnt_next  = bit_inc;
            if (data_done) begin
              bit_cnt_next  = 9'd0;
              chip_cnt_next = chip_cnt + 3'd1;
            end
          end
        end
        PH_FINISH: begin
          sclk_next     = 1'b0;
          chip_cnt_next = 3'd0;
        end
        default: begin
          cmd_idx_next = cmd_idx;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      cmd_idx  <= 3'd0;
      bit_cnt  <= 9'd0;
      chip_cnt <= 3'd0;
      slot_cnt <= 4'd0;
      cs       <= 1'b0;
      sclk     <= 1'b0;
      wr       <= 1'b0;
      sdata    <= 1'b0;
    end else begin
      phase    <= phase_next;
      cmd_idx  <= cmd_idx_next;
      bit_cnt  <= bit_cnt_next;
      chip_cnt <= chip_cnt_next;
      slot_cnt <= slot_cnt_next;
      cs       <= cs_next;
      sclk     <= sclk_next;
      wr       <= wr_next;
      sdata    <= sdata_next;
    end
  end

  // Pin registers only change on a step, which needs the result slot free,
  // so they double as the result payload.
  assign pins.valid        = out_valid;
  assign pins.select_line  = cs;
  assign pins.select_clock = sclk;
  assign pins.write_strobe = wr;
  assign pins.serial_data  = sdata;
  assign pins.busy_res     = (phase != PH_IDLE);

  `LMFS_CHECK(a_idle_clean, (phase != PH_IDLE) || counters_clear, "idle with counters set")
  `LMFS_CHECK(a_cmd_range, cmd_idx < SETUP_CMDS, "setup command index out of range")
  `LMFS_CHECK(a_chip_range, chip_cnt <= 3'(CHIP_COUNT), "chip counter past cascade")
  `LMFS_CHECK_NEXT(a_step_result, step, out_valid && !pending, "step did not post a result")
  `LMFS_CHECK_NEXT(a_wait_hold, pending && !out_free, pending && $stable(phase), "item moved")

endmodule

`default_nettype wire

### hw/rtl/lmfs_frame_store.sv
// Frame store: 128 x 8 single-write, single-read memory with registered read.
// Depends on lmfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lmfs_frame_store (
  input  wire                  clk,
  input  lmfs_pkg::store_wr_t  wr,
  input  wire                  rd_en,
  input  lmfs_pkg::addr_t      rd_addr,
  output lmfs_pkg::byte_t      rd_data
);
  import lmfs_pkg::*;

  byte_t mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire
